// ----- rtl/prsw_pkg.sv -----
// Shared types, constants and helpers for the loss-tolerant stop-and-wait sender.
package prsw_pkg;

  localparam int WINDOW_SIZE = 100;
  localparam int SLOT_W      = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int TOL_W       = 7;
  localparam int LOSS_W      = 7;
  localparam int LOSS_MAX    = 127;
  localparam int PCT_SCALE   = 100;
  localparam int CMP_W       = CNT_W + TOL_W + 1;
  localparam int EXT_W       = (CNT_W > LOSS_W) ? CNT_W : LOSS_W;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_AWAIT = 2'd1,
    PH_RETX  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ACT_TX_NEW     = 3'd0,
    ACT_WAIT_AGAIN = 3'd1,
    ACT_RETX       = 3'd2,
    ACT_DELIVERED  = 3'd3,
    ACT_GIVEN_UP   = 3'd4,
    ACT_IGNORED    = 3'd5
  } action_t;

  typedef struct packed {
    logic mode;
    logic reply_seen;
    logic reply_is_ack;
    logic reply_ack_bit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic              seq_bit;
    logic [LOSS_W-1:0] losses_in_window;
  } out_item_t;

  // Control from the sequencer to the loss window store.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_mark;
  } win_req_t;

  function automatic logic [LOSS_W-1:0] sat_loss(input logic [CNT_W-1:0] c);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(c);
    if (ext > EXT_W'(LOSS_MAX)) begin
      return LOSS_W'(LOSS_MAX);
    end
    return LOSS_W'(ext);
  endfunction

endpackage

// ----- rtl/prsw_window.sv -----
// Loss mark store: one bit per slot, valid bits cleared by reset, registered read.
module prsw_window import prsw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  win_req_t req,
  output logic     old_mark
);

  logic                   mark_mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] written;
  logic                   rd_data;
  logic                   rd_written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mark_mem[req.wr_addr] <= req.wr_mark;
    end
    if (req.rd_en) begin
      rd_data    <= mark_mem[req.rd_addr];
      rd_written <= written[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
    end
  end

  // never-written slot reads as clear
  assign old_mark = rd_data & rd_written;

endmodule

// ----- rtl/prsw_ctrl.sv -----
// Sequencer: phase, sequence bit, slot index and running loss count.
module prsw_ctrl import prsw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  in_item_t         item,
  input  logic [TOL_W-1:0] tol,
  input  logic             old_mark,
  output out_item_t        res,
  output win_req_t         win_req
);

  phase_t            phase, phase_next;
  logic              seq, seq_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [CNT_W-1:0]  count, count_next;

  logic              match;
  logic [SLOT_W-1:0] slot_inc;
  logic              dec_await;
  logic              dec_retx;
  logic [CNT_W-1:0]  cnt_fail;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;
  logic              over;
  action_t           action;

  assign match    = item.reply_seen & item.reply_is_ack & (item.reply_ack_bit == seq);
  assign slot_inc = (slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot + SLOT_W'(1);

  // slot under test holds an old mark; in retransmit it was just set
  assign dec_await = old_mark & (count != '0);
  assign dec_retx  = (count != '0);
  assign cnt_fail  = count - CNT_W'(dec_await) + CNT_W'(1);

  assign lhs  = CMP_W'(cnt_fail) * CMP_W'(PCT_SCALE);
  assign rhs  = CMP_W'(tol) * CMP_W'(WINDOW_SIZE);
  assign over = lhs > rhs;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (!item.mode) phase_next = PH_AWAIT;
      end
      PH_AWAIT: begin
        if (item.mode) phase_next = (!match && over) ? PH_RETX : PH_IDLE;
      end
      PH_RETX: begin
        if (item.mode && match) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    action     = ACT_IGNORED;
    seq_next   = seq;
    slot_next  = slot;
    count_next = count;
    win_req    = '0;
    win_req.rd_addr = slot_inc;
    win_req.wr_addr = slot;
    unique case (phase)
      PH_IDLE: begin
        if (!item.mode) begin
          action        = ACT_TX_NEW;
          slot_next     = slot_inc;
          win_req.rd_en = 1'b1;
        end
      end
      PH_AWAIT: begin
        if (item.mode) begin
          win_req.wr_en = 1'b1;
          if (match) begin
            action     = ACT_DELIVERED;
            count_next = count - CNT_W'(dec_await);
            seq_next   = ~seq;
          end else begin
            win_req.wr_mark = 1'b1;
            count_next      = cnt_fail;
            if (over) begin
              action = ACT_WAIT_AGAIN;
            end else begin
              action   = ACT_GIVEN_UP;
              seq_next = ~seq;
            end
          end
        end
      end
      PH_RETX: begin
        if (item.mode) begin
          if (match) begin
            action        = ACT_DELIVERED;
            win_req.wr_en = 1'b1;
            count_next    = count - CNT_W'(dec_retx);
            seq_next      = ~seq;
          end else begin
            action = ACT_RETX;
          end
        end
      end
      default: action = ACT_IGNORED;
    endcase
    win_req.rd_en  = win_req.rd_en & accept;
    win_req.wr_en  = win_req.wr_en & accept;
    res.action           = action;
    res.seq_bit          = seq;
    res.losses_in_window = sat_loss(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      seq   <= 1'b0;
      slot  <= '0;
      count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      seq   <= seq_next;
      slot  <= slot_next;
      count <= count_next;
    end
  end

endmodule

// ----- rtl/partial_reliability_stop_and_wait.sv -----
// Top level of the loss-tolerant stop-and-wait sender: ports, config and result register.
//
//  channel   dir   handshake            payload
//  -------   ---   ------------------   ----------------------------------
//  in        in    in_valid/in_ready    in_data  (mode, reply fields)
//  out       out   out_valid/out_ready  out_data (action, seq_bit, losses)
//  cfg       in    cfg_we               cfg_wdata (loss tolerance, percent)
//
// One beat in, one beat out. The result is registered and appears in the
// cycle after the input beat; a new beat is taken every cycle while the
// result register is empty or being drained, so throughput is one beat per cycle.
// Reset (rst, synchronous) clears phase, sequence bit, slot index, loss count
// and all window valid bits at once; the block accepts beats right after.
// A stalled output holds the result and holds in_ready low while it stalls.
module partial_reliability_stop_and_wait import prsw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  logic             accept;
  logic [TOL_W-1:0] tol;
  logic             old_mark;
  out_item_t        res;
  win_req_t         win_req;

  // input side free whenever the result register empties this cycle
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // loss tolerance register, written on cfg_we; no beat may be in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  prsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .tol      (tol),
    .old_mark (old_mark),
    .res      (res),
    .win_req  (win_req)
  );

  // mark of the slot fetched at transmit time, used on the first outcome
  prsw_window u_window (
    .clk      (clk),
    .rst      (rst),
    .req      (win_req),
    .old_mark (old_mark)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule

// ----- sim/partial_reliability_stop_and_wait_tb.sv -----
// Self-checking testbench for the loss-tolerant stop-and-wait sender.
module partial_reliability_stop_and_wait_tb;
  import prsw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  partial_reliability_stop_and_wait DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Beats waiting to be driven, and sender verdicts predicted for accepted beats.
  in_item_t  msg_events[$];
  out_item_t sender_verdicts[$];
  int        errors = 0;
  bit        steady = 1'b0;  // when set, neither side idles

  // Shadow copy of the sender state, advanced once per accepted input beat.
  logic             shadow_seq = 1'b0;
  int               shadow_slot = 0;
  bit               shadow_marks[WINDOW_SIZE];
  int               shadow_losses = 0;
  phase_t           shadow_phase = PH_IDLE;
  logic [TOL_W-1:0] shadow_tol = TOL_RESET;

  // Most gaps are zero, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One random bit.
  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Replace the mark of the current slot and keep the running loss count exact.
  function automatic void mark_slot(bit lost);
    if (shadow_marks[shadow_slot] && shadow_losses > 0) shadow_losses--;
    if (lost) shadow_losses++;
    shadow_marks[shadow_slot] = lost;
  endfunction

  function automatic out_item_t advance_sender(in_item_t ev);
    out_item_t r;
    logic      cur_bit;
    logic      match;
    cur_bit   = shadow_seq;
    match     = ev.reply_seen && ev.reply_is_ack && (ev.reply_ack_bit == cur_bit);
    r.seq_bit = cur_bit;  // bit of the message concerned, before any flip
    r.action  = ACT_IGNORED;
    if (!ev.mode) begin
      // A new message is only taken while idle; the slot advances before use.
      if (shadow_phase == PH_IDLE) begin
        shadow_slot  = (shadow_slot + 1) % WINDOW_SIZE;
        shadow_phase = PH_AWAIT;
        r.action     = ACT_TX_NEW;
      end
    end else begin
      case (shadow_phase)
        PH_AWAIT: begin
          if (match) begin
            mark_slot(1'b0);
            shadow_seq   = ~cur_bit;
            shadow_phase = PH_IDLE;
            r.action     = ACT_DELIVERED;
          end else begin
            mark_slot(1'b1);
            // Loss ratio test by cross-multiplying; tolerance used as written.
            if (shadow_losses * PCT_SCALE > int'(shadow_tol) * WINDOW_SIZE) begin
              shadow_phase = PH_RETX;
              r.action     = ACT_WAIT_AGAIN;
            end else begin
              shadow_seq   = ~cur_bit;
              shadow_phase = PH_IDLE;
              r.action     = ACT_GIVEN_UP;
            end
          end
        end
        PH_RETX: begin
          if (match) begin
            mark_slot(1'b0);
            shadow_seq   = ~cur_bit;
            shadow_phase = PH_IDLE;
            r.action     = ACT_DELIVERED;
          end else begin
            r.action = ACT_RETX;  // window untouched while retransmitting
          end
        end
        default: r.action = ACT_IGNORED;
      endcase
    end
    r.losses_in_window = (shadow_losses > LOSS_MAX) ? LOSS_W'(LOSS_MAX) : LOSS_W'(shadow_losses);
    return r;
  endfunction

  function automatic in_item_t make_item(bit mode, bit seen, bit is_ack, bit ack_bit);
    in_item_t it;
    it.mode          = mode;
    it.reply_seen    = seen;
    it.reply_is_ack  = is_ack;
    it.reply_ack_bit = ack_bit;
    return it;
  endfunction

  // One message: a send request, then a run of outcomes. Replies carry a
  // random ack bit, so roughly half of the acks match the live sequence bit.
  // Surplus outcomes after delivery land while idle and get ignored.
  task automatic queue_message(int ack_pct);
    int n;
    int i;
    n = $urandom_range(1, 5);
    msg_events.push_back(make_item(1'b0, coin(), coin(), coin()));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < ack_pct)
        msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, coin()));
      else
        msg_events.push_back(make_item(1'b1, coin(), coin(), coin()));
    end
  endtask

  // Wait until every queued beat is accepted and every verdict has come back.
  task automatic wait_drained();
    while (msg_events.size() != 0 || sender_verdicts.size() != 0) @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_tolerance(logic [TOL_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    shadow_tol = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Input driver: holds a beat until accepted, then idles a random gap.
  always @(posedge clk) begin : drive_in
    int       idle_left;
    logic     nxt_valid;
    in_item_t nxt_data;
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid && in_ready) begin
        sender_verdicts.push_back(advance_sender(in_data));
        void'(msg_events.pop_front());
        idle_left = pick_gap();
      end
      nxt_valid = 1'b0;
      nxt_data  = in_data;
      if (idle_left > 0) begin
        idle_left--;
      end else if (msg_events.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_data  = msg_events[0];
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Output monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin : watch_out
    int        stall_left;
    out_item_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sender_verdicts.size() == 0) begin
          $error("unexpected result beat: action %0d seq_bit %0d losses %0d",
                 out_data.action, out_data.seq_bit, out_data.losses_in_window);
          errors++;
        end else begin
          want = sender_verdicts.pop_front();
          if (out_data.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_data.action);
            errors++;
          end
          if (out_data.seq_bit !== want.seq_bit) begin
            $error("seq_bit: expected %0d, got %0d", want.seq_bit, out_data.seq_bit);
            errors++;
          end
          if (out_data.losses_in_window !== want.losses_in_window) begin
            $error("losses_in_window: expected %0d, got %0d",
                   want.losses_in_window, out_data.losses_in_window);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("partial_reliability_stop_and_wait_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [TOL_W-1:0] tols[6];
    int               ack_rates[6];
    int               p;
    int               k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset tolerance of 5 percent: a lone loss is below it.
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, 1'b1));  // outcome while idle
    msg_events.push_back(make_item(1'b0, 1'b0, 1'b0, 1'b0));  // first message, slot 1
    msg_events.push_back(make_item(1'b0, 1'b1, 1'b1, 1'b1));  // new message while waiting
    msg_events.push_back(make_item(1'b1, 1'b0, 1'b1, 1'b0));  // timeout, given up
    msg_events.push_back(make_item(1'b0, 1'b1, 1'b0, 1'b1));
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, 1'b0));  // ack for the wrong bit
    msg_events.push_back(make_item(1'b0, 1'b0, 1'b1, 1'b1));
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b0, 1'b0));  // reply without ack flag
    msg_events.push_back(make_item(1'b0, 1'b0, 1'b0, 1'b1));
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, 1'b1));  // matching ack, delivered
    wait_drained();

    // Zero tolerance: any loss forces the retransmit loop.
    write_tolerance(TOL_W'(0));
    msg_events.push_back(make_item(1'b0, 1'b0, 1'b0, 1'b0));  // seq 0
    msg_events.push_back(make_item(1'b1, 1'b0, 1'b0, 1'b0));  // wait again
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, 1'b1));  // wrong bit, retransmit
    msg_events.push_back(make_item(1'b0, 1'b1, 1'b1, 1'b0));  // new message mid-loop
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b0, 1'b0));  // retransmit
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, 1'b0));  // delivered, slot cleared
    msg_events.push_back(make_item(1'b0, 1'b0, 1'b0, 1'b0));
    msg_events.push_back(make_item(1'b1, 1'b1, 1'b1, 1'b1));  // delivered on first try
    wait_drained();

    // Top of range and out of range: nothing retransmits.
    write_tolerance(TOL_W'(100));
    msg_events.push_back(make_item(1'b0, 1'b0, 1'b0, 1'b0));
    msg_events.push_back(make_item(1'b1, 1'b0, 1'b0, 1'b1));
    wait_drained();
    write_tolerance(TOL_W'(127));
    msg_events.push_back(make_item(1'b0, 1'b1, 1'b1, 1'b1));
    msg_events.push_back(make_item(1'b1, 1'b0, 1'b1, 1'b1));
    wait_drained();

    // Random phases; each starts from a drained block, so the sender holds
    // off until all verdicts are back. Enough messages across the phases to
    // wrap the window, so stale marks get replaced.
    tols      = '{TOL_W'(5), TOL_W'(0), TOL_W'(100), TOL_W'(127), TOL_W'(30), TOL_W'(60)};
    ack_rates = '{40, 85, 20, 30, 55, 45};
    for (p = 0; p < 6; p++) begin
      if (p == 3) tols[p] = TOL_W'($urandom_range(0, 127));
      write_tolerance(tols[p]);
      steady = (p == 4);
      for (k = 0; k < 38; k++) begin
        if ($urandom_range(0, 9) == 0)
          msg_events.push_back(make_item(coin(), coin(), coin(), coin()));
        else
          queue_message(ack_rates[p]);
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (errors == 0 && sender_verdicts.size() == 0) begin
      $display("partial_reliability_stop_and_wait_tb: clean");
    end else begin
      $display("partial_reliability_stop_and_wait_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/prsw_pkg.sv
rtl/prsw_window.sv
rtl/prsw_ctrl.sv
rtl/partial_reliability_stop_and_wait.sv
sim/partial_reliability_stop_and_wait_tb.sv
